// ----- rtl/bis_pkg.sv -----
`timescale 1ns / 1ps

package bis_pkg;

   // Payload widths fixed by the transaction format
   localparam int VAL_W = 32;
   localparam int CAP_W = 7;
   localparam int POS_W = 6;
   localparam int CNT_W = 7;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Operation codes; the unused code behaves as a query
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

endpackage

// ----- rtl/bis_req_if.sv -----
`timescale 1ns / 1ps

interface bis_req_if import bis_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, req_type, value, input ready);
   modport sink   (input valid, req_type, value, output ready);
endinterface

// ----- rtl/bis_rsp_if.sv -----
`timescale 1ns / 1ps

interface bis_rsp_if import bis_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;
   logic             changed;
   logic [CNT_W-1:0] count;
   logic             full_res;

   modport source (output valid, found, position, changed, count, full_res, input ready);
   modport sink   (input valid, found, position, changed, count, full_res, output ready);
endinterface

// ----- rtl/bis_ram.sv -----
`timescale 1ns / 1ps

module bis_ram import bis_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [VAL_W-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [VAL_W-1:0] rdata
);

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rdata_ff;

   // Write one entry, read one entry through a registered output
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bounded_integer_set_table.sv -----
`timescale 1ns / 1ps

// Set of distinct 32-bit integers held packed in slots 0..count-1 of a single-port-read,
// single-port-write table of DEPTH entries. One request is worked at a time. The search
// reads one stored entry per cycle from the table and compares it in the next cycle. It
// stops at the first hit or after the last occupied slot. A remove that hits then reads
// the last entry and moves it into the freed slot. The next request is taken in the
// cycle after the result is loaded. A result waits in the output register while the
// next request is worked, and the block stalls only when that next result is ready
// before the waiting one is taken.
// The user must ensure capacity is written through csr_we/csr_wdata only while no
// request is in flight; the block does not enforce this. Values above DEPTH act as
// DEPTH. The table needs no clearing after reset: only slots below the count are ever
// compared or moved.
module bounded_integer_set_table import bis_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   bis_req_if.sink          req_bus,
   bis_rsp_if.source        rsp_bus,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_MOVE,
      S_RESULT
   } state_type;

   state_type        state_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    scan_ff;
   logic [AW-1:0]    cmp_ff;
   logic             pend_ff;
   logic             hit_ff;
   logic [AW-1:0]    slot_ff;
   logic             changed_ff;
   logic [1:0]       op_ff;
   logic [VAL_W-1:0] val_ff;

   logic             rsp_valid_ff;
   logic             found_ff;
   logic [POS_W-1:0] position_ff;
   logic             rsp_changed_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             full_ff;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [VAL_W-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [VAL_W-1:0] ram_rdata;

   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] count_ext;
   logic [CW-1:0]    last_idx;
   logic             hit_now;
   logic             add_ok;
   logic             out_free;

   // Saturate capacity to the table depth
   assign cap_eff   = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   assign count_ext = CMP_W'(count_ff);
   assign last_idx  = count_ff - 1'b1;
   assign hit_now   = pend_ff && (ram_rdata == val_ff);
   assign add_ok    = !hit_ff && (count_ext < cap_eff);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // Read the scan slot while searching, otherwise the last occupied slot
   assign ram_raddr = (state_ff == S_SEARCH) ? scan_ff[AW-1:0] : last_idx[AW-1:0];

   // Append on add, move the last entry into the hole on remove
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = val_ff;
      case (state_ff)
         S_DECIDE: begin
            ram_we = (op_ff == OP_ADD) && add_ok;
         end
         S_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = slot_ff;
            ram_wdata = ram_rdata;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   bis_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  op_ff      <= req_bus.req_type;
                  val_ff     <= req_bus.value;
                  scan_ff    <= '0;
                  pend_ff    <= 1'b0;
                  hit_ff     <= 1'b0;
                  slot_ff    <= '0;
                  changed_ff <= 1'b0;
                  state_ff   <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (hit_now) begin
                  hit_ff   <= 1'b1;
                  slot_ff  <= cmp_ff;
                  pend_ff  <= 1'b0;
                  state_ff <= S_DECIDE;
               end else if (!pend_ff && scan_ff == count_ff) begin
                  state_ff <= S_DECIDE;
               end else if (scan_ff != count_ff) begin
                  // advance to the next occupied slot
                  cmp_ff  <= scan_ff[AW-1:0];
                  scan_ff <= scan_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
            end
            S_DECIDE: begin
               if (op_ff == OP_ADD && add_ok) begin
                  count_ff   <= count_ff + 1'b1;
                  changed_ff <= 1'b1;
                  state_ff   <= S_RESULT;
               end else if (op_ff == OP_REMOVE && hit_ff) begin
                  state_ff <= S_MOVE;
               end else begin
                  state_ff <= S_RESULT;
               end
            end
            S_MOVE: begin
               count_ff   <= last_idx;
               changed_ff <= 1'b1;
               state_ff   <= S_RESULT;
            end
            S_RESULT: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  found_ff       <= hit_ff;
                  position_ff    <= POS_W'(slot_ff);
                  rsp_changed_ff <= changed_ff;
                  rsp_count_ff   <= CNT_W'(count_ff);
                  full_ff        <= (count_ext >= cap_eff);
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.found     = found_ff;
   assign rsp_bus.position  = position_ff;
   assign rsp_bus.changed   = rsp_changed_ff;
   assign rsp_bus.count     = rsp_count_ff;
   assign rsp_bus.full_res  = full_ff;

   // Count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above table depth");

   // Table writes happen only at the end of a transaction
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_DECIDE || state_ff == S_MOVE))
      else $error("table written outside update phase");

   // A hit always lies inside the occupied slots
   a_hit_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && hit_ff) |-> (CW'(slot_ff) < count_ff))
      else $error("hit slot outside occupied range");

   // A move shrinks the set by one
   a_move_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not decrement count");

endmodule

// ----- test/bis_checker.sv -----
`timescale 1ns / 1ps

module bis_checker import bis_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   bis_req_if               req_mon,
   bis_rsp_if               rsp_mon,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   output int               mismatch_count,
   output int               outstanding
);

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic             changed;
      logic [CNT_W-1:0] count;
      logic             full_res;
   } set_outcome_t;

   // Shadow copy of the set and its capacity register
   logic [VAL_W-1:0] entry_table [DEPTH];
   int               live_count;
   logic [CAP_W-1:0] capacity_q;
   set_outcome_t     outcome_q [$];
   set_outcome_t     want;
   set_outcome_t     got;

   // Apply one request to the shadow set and return the outcome it should produce
   function automatic set_outcome_t apply_request(logic [1:0] kind, logic [VAL_W-1:0] v);
      set_outcome_t res;
      int           slot;
      int           limit;
      int           k;
      logic         hit;
      limit = (capacity_q > DEPTH) ? DEPTH : capacity_q;
      hit   = 1'b0;
      slot  = 0;
      for (k = 0; k < live_count; k++) begin
         if (!hit && entry_table[k] == v) begin
            hit  = 1'b1;
            slot = k;
         end
      end
      res.changed = 1'b0;
      if (kind == OP_ADD) begin
         if (!hit && live_count < limit) begin
            entry_table[live_count] = v;
            live_count++;
            res.changed = 1'b1;
         end
      end else if (kind == OP_REMOVE) begin
         // Move the last entry into the freed slot
         if (hit) begin
            live_count--;
            entry_table[slot] = entry_table[live_count];
            res.changed = 1'b1;
         end
      end
      res.found    = hit;
      res.position = slot[POS_W-1:0];
      res.count    = live_count[CNT_W-1:0];
      res.full_res = (live_count >= limit);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Compare each result transaction with the oldest outcome, then record new requests
   always @(posedge clock) begin
      if (reset) begin
         live_count     = 0;
         capacity_q     = CAP_RESET;
         mismatch_count = 0;
         outcome_q.delete();
      end else begin
         if (csr_we)
            capacity_q = csr_wdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result transaction with no request outstanding");
            end else begin
               want = outcome_q.pop_front();
               got  = '{rsp_mon.found, rsp_mon.position, rsp_mon.changed,
                        rsp_mon.count, rsp_mon.full_res};
               if (got.found !== want.found)
                  report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
               if (got.position !== want.position)
                  report_mismatch($sformatf("position %0d, want %0d",
                                            got.position, want.position));
               if (got.changed !== want.changed)
                  report_mismatch($sformatf("changed %0b, want %0b",
                                            got.changed, want.changed));
               if (got.count !== want.count)
                  report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
               if (got.full_res !== want.full_res)
                  report_mismatch($sformatf("full_res %0b, want %0b",
                                            got.full_res, want.full_res));
            end
         end
         if (req_mon.valid && req_mon.ready)
            outcome_q.push_back(apply_request(req_mon.req_type, req_mon.value));
      end
      outstanding = outcome_q.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import bis_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         HOLD_AT        = 150;
   localparam int         PHASE_ITEMS    = 240;
   localparam logic [31:0] INT_MIN       = 32'h8000_0000;
   localparam logic [31:0] INT_MAX       = 32'h7FFF_FFFF;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;
   int               mismatch_count;
   int               outstanding;
   int               sent_total;
   int               rsp_total;
   int               idle_cycles;
   logic [31:0]      value_pool [96];

   bis_req_if req_bus ();
   bis_rsp_if rsp_bus ();

   bounded_integer_set_table #(.DEPTH(64)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bis_checker #(.DEPTH(64)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input logic [31:0] v);
      int gap;
      gap = ((sent_total % 256) < 48) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.req_type = kind;
      req_bus.value    = v;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_total++;
   endtask

   // Write the capacity register once the block has drained
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = cap;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Response side: random back-pressure, no-stall stretches and one long hold
   initial begin : receiver
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_total == HOLD_AT)
            gap = HOLD_CYCLES;
         else
            gap = (((rsp_total + 128) % 256) < 48) ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
         rsp_total++;
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("bounded_integer_set_table: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int          cap_plan [8];
      int          add_plan [8];
      int          phase;
      int          n;
      int          r;
      logic [1:0]  kind;
      logic [31:0] v;
      cap_plan = '{127, 64, 3, 0, 40, 1, 100, 0};
      add_plan = '{70, 65, 50, 50, 45, 50, 60, 50};
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = OP_QUERY;
      req_bus.value    = '0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      sent_total       = 0;
      rsp_total        = 0;
      idle_cycles      = 0;
      foreach (value_pool[i])
         value_pool[i] = $urandom;
      value_pool[0] = INT_MIN;
      value_pool[1] = INT_MAX;
      value_pool[2] = '0;
      value_pool[3] = '1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Empty set, extreme values, duplicates and the unused code
      send_request(OP_QUERY, 32'd0);
      send_request(OP_REMOVE, 32'd5);
      send_request(OP_ADD, INT_MIN);
      send_request(OP_ADD, INT_MAX);
      send_request(OP_ADD, 32'd0);
      send_request(OP_ADD, '1);
      send_request(OP_ADD, INT_MAX);
      send_request(OP_QUERY, INT_MIN);
      send_request(OP_UNUSED, '1);
      send_request(OP_UNUSED, 32'd7);
      send_request(OP_REMOVE, INT_MIN);
      send_request(OP_QUERY, '1);
      send_request(OP_REMOVE, 32'd12345);

      // Capacity below the current count
      write_capacity(7'd2);
      send_request(OP_ADD, 32'd9);
      send_request(OP_REMOVE, INT_MAX);
      send_request(OP_QUERY, 32'd0);

      // Zero capacity refuses every add
      write_capacity(7'd0);
      send_request(OP_ADD, 32'd1);
      send_request(OP_REMOVE, 32'd0);
      send_request(OP_REMOVE, '1);
      send_request(OP_ADD, 32'd3);

      // Capacity above the table depth
      write_capacity(7'd127);
      send_request(OP_ADD, 32'h5555_5555);
      send_request(OP_ADD, 32'hAAAA_AAAA);

      // Random phases: mostly pool values so that adds and removes hit
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 7)
            write_capacity(CAP_W'($urandom_range(0, 127)));
         else
            write_capacity(CAP_W'(cap_plan[phase]));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < add_plan[phase])
               kind = OP_ADD;
            else begin
               r = $urandom_range(0, 9);
               kind = (r < 6) ? OP_REMOVE : (r < 9) ? OP_QUERY : OP_UNUSED;
            end
            if ($urandom_range(0, 99) < 85)
               v = value_pool[$urandom_range(0, 95)];
            else
               v = $urandom;
            send_request(kind, v);
         end
      end

      // Drain and give the verdict
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("bounded_integer_set_table: match");
      else
         $display("bounded_integer_set_table: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bis_pkg.sv
rtl/bis_req_if.sv
rtl/bis_rsp_if.sv
rtl/bis_ram.sv
rtl/bounded_integer_set_table.sv
test/bis_checker.sv
test/testbench.sv
